// ===== design/ptss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared sizes and controller/datapath interface types for the periodic
// timer slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = 32;
  localparam int PER_W   = 16;
  localparam int SEL_W   = 3;
  localparam int BITS_W  = $clog2(CNT_W);

  // input tuser codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic load;        // write one slot from the input item
    logic tick;        // advance counter, restart slot walk
    logic div_start;   // load divider with counter
    logic div_step;    // one restoring step
    logic fire;        // decrement slot, hold result as pending
    logic next_slot;   // advance slot index
    logic flush;       // send pending result with last marker
  } ptss_cmd_t;

  typedef struct packed {
    logic slot_active;
    logic div_last;
    logic rem_zero;
    logic last_slot;
    logic pend_valid;
    logic out_free;
  } ptss_stat_t;

endpackage
`default_nettype wire

// ===== design/ptss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_ctrl
// Sequencer: takes items, walks the slots and drives the serial modulo.
// ----------------------------------------------------------------------------
module ptss_ctrl
  import ptss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_ready,
  input  ptss_stat_t stat,
  output ptss_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  state_t state;
  logic   can_fire;

  // a fire pushes the held result out, so the output register must be free
  assign can_fire = !stat.pend_valid || stat.out_free;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && (in_mode == MODE_LOAD);
        cmd.tick = in_valid && (in_mode == MODE_TICK);
      end
      ST_CHECK: begin
        cmd.div_start = stat.slot_active;
        cmd.next_slot = !stat.slot_active;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DECIDE: begin
        cmd.fire      = stat.rem_zero && can_fire;
        cmd.next_slot = !stat.rem_zero || can_fire;
      end
      ST_FLUSH: begin
        cmd.flush = stat.pend_valid && stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (in_mode == MODE_TICK)) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (stat.slot_active) state <= ST_DIV;
          else if (stat.last_slot) state <= ST_FLUSH;
        end
        ST_DIV: begin
          if (stat.div_last) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (cmd.next_slot) state <= stat.last_slot ? ST_FLUSH : ST_CHECK;
        end
        ST_FLUSH: begin
          if (!stat.pend_valid || stat.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ptss_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_dp
// Datapath: tick counter, slot tables, bit-serial 32/16 modulo, pending
// result and output register.
// ----------------------------------------------------------------------------
module ptss_dp
  import ptss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ptss_cmd_t          cmd,
  output ptss_stat_t         stat,
  input  logic [SEL_W-1:0]   sel,
  input  logic [PER_W-1:0]   period,
  input  logic [PER_W-1:0]   count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SEL_W-1:0]   out_idx,
  output logic [PER_W-1:0]   out_rem,
  output logic               out_last
);

  logic [CNT_W-1:0]  tick_counter;
  logic [PER_W-1:0]  slot_period    [SLOTS];
  logic [PER_W-1:0]  slot_remaining [SLOTS];
  logic [SLOT_W-1:0] idx;

  logic [CNT_W-1:0]  dvd;
  logic [PER_W-1:0]  rem;
  logic [BITS_W-1:0] bit_cnt;

  logic [SLOT_W-1:0] pend_idx;
  logic [PER_W-1:0]  pend_rem;
  logic              pend_valid;

  logic [PER_W-1:0]  cur_period;
  logic [PER_W-1:0]  cur_remaining;
  logic [PER_W:0]    shifted;
  logic [PER_W:0]    diff;
  logic [PER_W-1:0]  trial;
  logic              push;
  logic              load_ok;

  assign cur_period    = slot_period[idx];
  assign cur_remaining = slot_remaining[idx];

  // restoring step: remainder stays below the period, so 16 bits suffice
  assign shifted = {rem, dvd[CNT_W-1]};
  assign diff    = shifted - {1'b0, cur_period};
  assign trial   = diff[PER_W] ? shifted[PER_W-1:0] : diff[PER_W-1:0];

  assign load_ok = (32'(sel) < 32'(SLOTS));
  assign push    = (cmd.fire && pend_valid) || cmd.flush;

  assign stat.slot_active = (cur_remaining != '0) && (cur_period != '0);
  assign stat.div_last    = (bit_cnt == BITS_W'(CNT_W - 1));
  assign stat.rem_zero    = (rem == '0);
  assign stat.last_slot   = (idx == SLOT_W'(SLOTS - 1));
  assign stat.pend_valid  = pend_valid;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        slot_period[k]    <= '0;
        slot_remaining[k] <= '0;
      end
    end else begin
      if (cmd.load && load_ok) begin
        slot_period[SLOT_W'(sel)]    <= period;
        slot_remaining[SLOT_W'(sel)] <= count;
      end
      if (cmd.tick) tick_counter <= tick_counter + 1'b1;
      if (cmd.fire) slot_remaining[idx] <= cur_remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.tick) begin
      idx <= '0;
    end else if (cmd.next_slot && !stat.last_slot) begin
      idx <= idx + 1'b1;
    end
  end

  // serial modulo, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd     <= tick_counter;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[CNT_W-2:0], 1'b0};
      rem     <= trial;
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  // one result is held back until we know whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.fire) begin
      pend_valid <= 1'b1;
    end else if (cmd.tick || cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      pend_idx <= idx;
      pend_rem <= cur_remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_idx  <= SEL_W'(pend_idx);
      out_rem  <= pend_rem;
      out_last <= cmd.flush;
    end
  end

endmodule
`default_nettype wire

// ===== design/periodic_timer_slot_scheduler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_slot_scheduler_top
// Tick counter with eight periodic timer slots; each tick reports the active
// slots whose period divides the new count.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser / tlast
//  s_axis   in   slot_select, period_ticks, repeat_count tuser = mode
//  m_axis   out  slot_index, remaining                   tlast = last_of_run
//
//  Load item: accepted while idle, next item may follow immediately.
//  Tick item: walks the slots in order, running the 32-step serial modulo
//  for each active slot and skipping inactive ones.
//  Output stalls hold the slot walk only at a firing or at the final flush.
//  rst is synchronous; it clears the counter and all slots.
// ----------------------------------------------------------------------------
module periodic_timer_slot_scheduler_top
  import ptss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // slot_select[2:0], period_ticks[18:3],
                                      // repeat_count[34:19], zero pad
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // slot_index[2:0], remaining[18:3], zero pad
  output logic        m_axis_tlast
);

  ptss_cmd_t         cmd;
  ptss_stat_t        stat;
  logic [SEL_W-1:0]  out_idx;
  logic [PER_W-1:0]  out_rem;

  ptss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sel       (s_axis_tdata[2:0]),
    .period    (s_axis_tdata[18:3]),
    .count     (s_axis_tdata[34:19]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_idx   (out_idx),
    .out_rem   (out_rem),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_rem, out_idx};

  // no held result survives the end of a tick
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !stat.pend_valid)
    else $error("pending result left while idle");

  // a tick item always starts a slot walk
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_TICK) |=> !s_axis_tready)
    else $error("tick accepted without slot walk");

  // only an active slot can fire
  a_fire_active: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> stat.slot_active && stat.rem_zero)
    else $error("fire on inactive slot or nonzero remainder");

endmodule
`default_nettype wire
